[sv/sctq_pkg.sv]
// ----------------------------------------------------------------------------
// Symmetric cost table package
// Shared constants, codes and structures of the symmetric cost table.
// ----------------------------------------------------------------------------
package sctq_pkg;

   localparam int MAX_UNITS_DEF = 256;
   localparam int CMD_DEPTH_DEF = 4;
   localparam int RSP_DEPTH_DEF = 4;

   localparam int OP_W       = 2;
   localparam int INDEX_W    = 8;
   localparam int BYTE_W     = 8;
   localparam int COST_W     = 16;
   localparam int NUM_W      = 9;
   localparam int PAIR_AW    = 15;
   localparam int PROD_W     = COST_W + BYTE_W;
   localparam int FRAC_W     = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [OP_W-1:0] OP_READ       = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE_RAW  = 2'd1;
   localparam logic [OP_W-1:0] OP_WRITE_COST = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE       = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_INSTANCES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEVEL     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEVEL     = 2'd2;

   localparam logic [NUM_W-1:0]  NUM_INSTANCES_RST = 9'd256;
   localparam logic [BYTE_W-1:0] MIN_LEVEL_RST     = 8'd0;
   localparam logic [BYTE_W-1:0] MAX_LEVEL_RST     = 8'd255;

   typedef enum logic [1:0] {
      KIND_IMM  = 2'd0,
      KIND_READ = 2'd1,
      KIND_RAW  = 2'd2,
      KIND_COST = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      logic [NUM_W-1:0]  num_instances;
      logic [BYTE_W-1:0] min_level;
      logic [BYTE_W-1:0] max_level;
   } cfg_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic               store_en;
      logic [PAIR_AW-1:0] addr;
      logic [BYTE_W-1:0]  data;
      logic               err;
      logic [PROD_W-1:0]  prod;
   } cmd_type;

   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic              index_error;
   } rsp_type;

endpackage

[sv/sctq_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module sctq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32640,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/sctq_fifo.sv]
// ----------------------------------------------------------------------------
// Small synchronous FIFO
// Register-based queue with occupancy count.
// ----------------------------------------------------------------------------
module sctq_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic             full,
   output logic [CW-1:0]    count
);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == CW'(0));
   assign full    = (count_ff == CW'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? PW'(0) : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? PW'(0) : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = data_ff[rd_ptr_ff];
   assign count    = count_ff;

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("FIFO push while full");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("FIFO occupancy beyond depth");

endmodule

[sv/sctq_front.sv]
// ----------------------------------------------------------------------------
// Symmetric cost table front end
// Checks indices, forms the packed pair address and the cost product, and
// classifies each request into a command for the back end.
// ----------------------------------------------------------------------------
module sctq_front #(
   parameter int MAX_UNITS = sctq_pkg::MAX_UNITS_DEF
) (
   input  logic                                  req_push,
   input  logic [sctq_pkg::OP_W-1:0]             req_operation,
   input  logic [sctq_pkg::INDEX_W-1:0]          req_index_a,
   input  logic [sctq_pkg::INDEX_W-1:0]          req_index_b,
   input  logic [sctq_pkg::BYTE_W-1:0]           req_raw_value,
   input  logic [sctq_pkg::COST_W-1:0]           req_cost,
   input  sctq_pkg::cfg_type                     cfg,
   input  logic                                  cmd_full,
   output logic                                  cmd_push,
   output sctq_pkg::cmd_type                     cmd
);
   import sctq_pkg::*;

   logic [INDEX_W-1:0] hi, lo;
   logic [2*INDEX_W-1:0] tri_prod;
   logic [BYTE_W-1:0] q;
   logic err, diag;

   assign cmd_push = req_push && !cmd_full;

   always_comb begin
      hi       = (req_index_a > req_index_b) ? req_index_a : req_index_b;
      lo       = (req_index_a > req_index_b) ? req_index_b : req_index_a;
      tri_prod = (2*INDEX_W)'(hi) * (2*INDEX_W)'(hi - INDEX_W'(1));
      q        = cfg.max_level - cfg.min_level;
      diag     = (req_index_a == req_index_b);
      err      = ({1'b0, req_index_a} >= cfg.num_instances)
              || ({1'b0, req_index_b} >= cfg.num_instances)
              || (32'(req_index_a) >= MAX_UNITS)
              || (32'(req_index_b) >= MAX_UNITS);

      cmd.addr     = PAIR_AW'(tri_prod >> 1) + PAIR_AW'(lo);
      cmd.prod     = PROD_W'(req_cost) * PROD_W'(q);
      cmd.kind     = KIND_IMM;
      cmd.store_en = 1'b0;
      cmd.data     = '0;
      cmd.err      = 1'b0;

      if (req_operation == OP_NONE) begin
         cmd.kind = KIND_IMM;
      end else if (err) begin
         cmd.err = 1'b1;
      end else begin
         unique case (req_operation)
            OP_READ: begin
               if (diag) begin
                  cmd.data = cfg.min_level;
               end else begin
                  cmd.kind = KIND_READ;
               end
            end
            OP_WRITE_RAW: begin
               cmd.kind     = KIND_RAW;
               cmd.data     = req_raw_value;
               cmd.store_en = !diag;
            end
            default: begin
               cmd.kind     = KIND_COST;
               cmd.store_en = !diag;
            end
         endcase
      end
   end

endmodule

[sv/sctq_back.sv]
// ----------------------------------------------------------------------------
// Symmetric cost table back end
// Quantizes costs, performs the store access and queues the responses.
// ----------------------------------------------------------------------------
module sctq_back #(
   parameter int MAX_UNITS = sctq_pkg::MAX_UNITS_DEF,
   parameter int RSP_DEPTH = sctq_pkg::RSP_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sctq_pkg::cfg_type           cfg,
   input  logic                        cmd_empty,
   input  sctq_pkg::cmd_type           cmd,
   output logic                        cmd_pop,
   input  logic                        rsp_pop,
   output logic                        rsp_empty,
   output logic [sctq_pkg::BYTE_W-1:0] rsp_value,
   output logic                        rsp_index_error
);
   import sctq_pkg::*;

   localparam int DEPTH = MAX_UNITS * (MAX_UNITS - 1) / 2;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RCW   = $clog2(RSP_DEPTH + 1);

   logic [BYTE_W-1:0] q, level, wdata, rdata;
   logic [PROD_W-1:0] max_bound;
   logic [PROD_W-FRAC_W-1:0] whole;
   logic [PROD_W-FRAC_W:0] rounded;
   logic [FRAC_W-1:0] frac;
   logic round_up, issue, ram_we;
   logic s1_valid_ff, s1_valid_in;
   logic s1_read_ff, s1_read_in;
   logic s1_err_ff, s1_err_in;
   logic [BYTE_W-1:0] s1_value_ff, s1_value_in;
   logic [RCW-1:0] rsp_count;
   logic rsp_full;
   rsp_type rsp_in, rsp_out;

   always_comb begin
      q         = cfg.max_level - cfg.min_level;
      max_bound = PROD_W'({q - BYTE_W'(1), FRAC_W'(0)});
      whole     = cmd.prod[PROD_W-1:FRAC_W];
      frac      = cmd.prod[FRAC_W-1:0];
      round_up  = (frac > {1'b1, (FRAC_W-1)'(0)})
               || ((frac == {1'b1, (FRAC_W-1)'(0)}) && whole[0]);
      rounded   = {1'b0, whole} + (PROD_W-FRAC_W+1)'(round_up);
      priority if (cfg.max_level <= cfg.min_level) begin
         level = cfg.min_level;
      end else if (cmd.prod >= max_bound) begin
         level = cfg.max_level;
      end else if (cmd.prod <= PROD_W'(1 << FRAC_W)) begin
         level = cfg.min_level;
      end else if (rounded > (PROD_W-FRAC_W+1)'(255)) begin
         level = 8'hFF;
      end else begin
         level = BYTE_W'(rounded);
      end
   end

   assign issue   = !cmd_empty && ((32'(rsp_count) + 32'(s1_valid_ff)) < RSP_DEPTH);
   assign cmd_pop = issue;
   assign wdata   = (cmd.kind == KIND_RAW) ? cmd.data : level;
   assign ram_we  = issue && cmd.store_en;

   sctq_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .addr (AW'(cmd.addr)),
      .wdata(wdata),
      .rdata(rdata)
   );

   always_comb begin
      s1_valid_in = issue;
      s1_read_in  = (cmd.kind == KIND_READ);
      s1_err_in   = cmd.err;
      s1_value_in = (cmd.kind == KIND_COST) ? level : cmd.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_read_ff  <= s1_read_in;
      s1_err_ff   <= s1_err_in;
      s1_value_ff <= s1_value_in;
   end

   assign rsp_in.value       = s1_read_ff ? rdata : s1_value_ff;
   assign rsp_in.index_error = s1_err_ff;

   sctq_fifo #(
      .WIDTH($bits(rsp_type)),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (s1_valid_ff),
      .push_data(rsp_in),
      .pop      (rsp_pop),
      .pop_data (rsp_out),
      .empty    (rsp_empty),
      .full     (rsp_full),
      .count    (rsp_count)
   );

   assign rsp_value       = rsp_out.value;
   assign rsp_index_error = rsp_out.index_error;

   a_read_reaches_stage: assert property (@(posedge clock) disable iff (reset)
      (issue && (cmd.kind == KIND_READ)) |=> (s1_valid_ff && s1_read_ff))
      else $error("Issued read did not reach the response stage");

   a_room_for_response: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !rsp_full)
      else $error("Response stage has no room in the response queue");

endmodule

[sv/symmetric_cost_table_with_quantizer_top.sv]
// ----------------------------------------------------------------------------
// Symmetric cost table with quantizer
// Packed lower-triangular byte store of pairwise costs with a Q4.12 cost
// quantizer, a command queue between front and back end, and a response queue.
//
//   channel   handshake              payload
//   req       req_push / req_full    operation, index_a, index_b, raw_value, cost
//   rsp       rsp_pop / rsp_empty    value, index_error
//   csr       csr_valid / csr_ready  csr_index, csr_data
//
// One item per cycle is sustained while responses are popped, set by the single
// store port in the back end. Requests pass the command queue, response stage and
// response queue. Reset empties both queues and loads the register defaults; the
// store contents are undefined until written. When responses are not popped the
// response queue fills and then the command queue, raising req_full.
// ----------------------------------------------------------------------------
module symmetric_cost_table_with_quantizer_top #(
   parameter int MAX_UNITS = sctq_pkg::MAX_UNITS_DEF,
   parameter int CMD_DEPTH = sctq_pkg::CMD_DEPTH_DEF,
   parameter int RSP_DEPTH = sctq_pkg::RSP_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [sctq_pkg::OP_W-1:0]       req_operation,
   input  logic [sctq_pkg::INDEX_W-1:0]    req_index_a,
   input  logic [sctq_pkg::INDEX_W-1:0]    req_index_b,
   input  logic [sctq_pkg::BYTE_W-1:0]     req_raw_value,
   input  logic [sctq_pkg::COST_W-1:0]     req_cost,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [sctq_pkg::BYTE_W-1:0]     rsp_value,
   output logic                            rsp_index_error,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sctq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sctq_pkg::CSR_DATA_W-1:0] csr_data
);
   import sctq_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd_front, cmd_back;
   logic cmd_push, cmd_pop, cmd_full, cmd_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_NUM_INSTANCES: cfg_in.num_instances = csr_data;
            CSR_MIN_LEVEL:     cfg_in.min_level     = BYTE_W'(csr_data);
            CSR_MAX_LEVEL:     cfg_in.max_level     = BYTE_W'(csr_data);
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_instances <= NUM_INSTANCES_RST;
         cfg_ff.min_level     <= MIN_LEVEL_RST;
         cfg_ff.max_level     <= MAX_LEVEL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sctq_front #(
      .MAX_UNITS(MAX_UNITS)
   ) u_front (
      .req_push     (req_push),
      .req_operation(req_operation),
      .req_index_a  (req_index_a),
      .req_index_b  (req_index_b),
      .req_raw_value(req_raw_value),
      .req_cost     (req_cost),
      .cfg          (cfg_ff),
      .cmd_full     (cmd_full),
      .cmd_push     (cmd_push),
      .cmd          (cmd_front)
   );

   assign req_full = cmd_full;

   sctq_fifo #(
      .WIDTH($bits(cmd_type)),
      .DEPTH(CMD_DEPTH)
   ) u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_data(cmd_front),
      .pop      (cmd_pop),
      .pop_data (cmd_back),
      .empty    (cmd_empty),
      .full     (cmd_full),
      .count    ()
   );

   sctq_back #(
      .MAX_UNITS(MAX_UNITS),
      .RSP_DEPTH(RSP_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .cmd_empty      (cmd_empty),
      .cmd            (cmd_back),
      .cmd_pop        (cmd_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_value      (rsp_value),
      .rsp_index_error(rsp_index_error)
   );

endmodule
